[rtl/assert_macros.svh]
// Assertion macros for the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LMFR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmfr checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define LMFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmfr checker: next-cycle property failed");

`endif

[rtl/lmfr_pkg.sv]
`timescale 1ns / 1ps

package lmfr_pkg;

  // Panel geometry defaults and limits
  localparam int MODULES_DEF    = 16;
  localparam int MODULES_MAX    = 32;
  localparam int PANEL_SIDE_DEF = 32;
  localparam int ROWS           = 8;
  localparam int ROW_W          = $clog2(ROWS);
  localparam int GRP_W          = $clog2((MODULES_MAX + 7) / 8);

  // Driver register addresses and limits
  localparam logic [3:0] DIGIT_BASE    = 4'd1;
  localparam logic [3:0] INTENSITY_REG = 4'd10;
  localparam logic [7:0] MAX_BRIGHT    = 8'd15;

  // Operation codes
  typedef enum logic [2:0] {
    FN_PIXEL  = 3'd0,
    FN_CLEAR  = 3'd1,
    FN_SHOW   = 3'd2,
    FN_BRIGHT = 3'd3,
    FN_RAW    = 3'd4
  } func_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             pix_write;
    logic             clear;
    logic             latch_cmd;
    logic             bright;
    logic             rd_en;
    logic             load_mem;
    logic             load_bcast;
    logic [ROW_W-1:0] row;
    logic [GRP_W-1:0] grp;
    logic             frame_end;
    logic             last;
  } lmfr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } lmfr_stat_t;

endpackage

[rtl/lmfr_op_if.sv]
`timescale 1ns / 1ps

interface lmfr_op_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] x;
  logic [7:0] y;
  logic       color;
  logic [3:0] cmd_address;
  logic [7:0] cmd_data;

  modport source (output valid, func, x, y, color, cmd_address, cmd_data, input ready);
  modport sink (input valid, func, x, y, color, cmd_address, cmd_data, output ready);
endinterface

[rtl/lmfr_grp_if.sv]
`timescale 1ns / 1ps

interface lmfr_grp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reg_address;
  logic [63:0] payload;
  logic        group_index;
  logic        frame_end;
  logic        last;

  modport source (output valid, reg_address, payload, group_index, frame_end, last,
                  input ready);
  modport sink (input valid, reg_address, payload, group_index, frame_end, last,
                output ready);
endinterface

[rtl/lmfr_ctrl.sv]
`timescale 1ns / 1ps

module lmfr_ctrl import lmfr_pkg::*; #(
  parameter int MODULES = MODULES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] in_func,
  output logic       in_ready,
  input  lmfr_stat_t stat,
  output lmfr_cmd_t  cmd
);

  localparam int GROUPS = (MODULES + 7) / 8;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_LOAD  = 4'b0100,
    S_BCAST = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [ROW_W-1:0] row, row_next;
  logic [GRP_W-1:0] grp, grp_next;
  logic             grp_end;
  logic             row_end;

  assign grp_end  = (grp == GRP_W'(GROUPS - 1));
  assign row_end  = (row == ROW_W'(ROWS - 1));
  assign in_ready = (state == S_IDLE);

  // Decode operations and step through rows and groups
  always_comb begin
    state_next    = state;
    row_next      = row;
    grp_next      = grp;
    cmd           = '0;
    cmd.row       = row;
    cmd.grp       = grp;
    cmd.frame_end = grp_end;
    cmd.last      = grp_end && ((state == S_BCAST) || row_end);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (func_t'(in_func))
            FN_PIXEL: cmd.pix_write = 1'b1;
            FN_CLEAR: cmd.clear = 1'b1;
            FN_SHOW: begin
              row_next   = '0;
              grp_next   = '0;
              state_next = S_READ;
            end
            FN_BRIGHT, FN_RAW: begin
              cmd.latch_cmd = 1'b1;
              cmd.bright    = (func_t'(in_func) == FN_BRIGHT);
              grp_next      = '0;
              state_next    = S_BCAST;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_mem = 1'b1;
          if (grp_end) begin
            grp_next = '0;
            if (row_end) begin
              state_next = S_IDLE;
            end else begin
              row_next   = row + ROW_W'(1);
              state_next = S_READ;
            end
          end else begin
            grp_next   = grp + GRP_W'(1);
            state_next = S_READ;
          end
        end
      end
      S_BCAST: begin
        if (stat.out_free) begin
          cmd.load_bcast = 1'b1;
          if (grp_end) begin
            grp_next   = '0;
            state_next = S_IDLE;
          end else begin
            grp_next = grp + GRP_W'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      grp   <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      grp   <= grp_next;
    end
  end

endmodule

[rtl/lmfr_datapath.sv]
`timescale 1ns / 1ps

module lmfr_datapath import lmfr_pkg::*; #(
  parameter int MODULES    = MODULES_DEF,
  parameter int PANEL_SIDE = PANEL_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic       color,
  input  logic [3:0] cmd_address,
  input  logic [7:0] cmd_data,
  input  lmfr_cmd_t  cmd,
  output lmfr_stat_t stat,
  lmfr_grp_if.source rsp
);

  localparam int GROUPS = (MODULES + 7) / 8;
  localparam int DEPTH  = ROWS * GROUPS;
  localparam int AW     = $clog2(DEPTH);
  localparam int TX_W   = $clog2(((PANEL_SIDE + 7) / 8) * PANEL_SIDE);

  // One 64-bit word per row and group of eight modules
  logic [63:0]     mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [TX_W-1:0] tx;
  logic [2:0]      ty;
  logic            pix_ok;
  logic            pix_we;
  logic [AW-1:0]   waddr;
  logic [5:0]      wbit;
  logic [AW-1:0]   raddr;
  logic [63:0]     rd_word;
  logic            rd_ok;

  logic [3:0]      bc_addr;
  logic [7:0]      bc_byte;
  logic [63:0]     bc_word;

  logic            out_valid;
  logic [3:0]      out_addr;
  logic [63:0]     out_payload;
  logic            out_grp;
  logic            out_fend;
  logic            out_last;

  // Map panel coordinates to word address and bit; module byte b of a group
  // sits at bits 63-8b down, so the word bit is 63 minus tx mod 64
  assign tx     = TX_W'(32'(x[7:3]) * PANEL_SIDE + PANEL_SIDE - 1 - 32'(y));
  assign ty     = ~x[2:0];
  assign pix_ok = (x < 8'(PANEL_SIDE)) && (y < 8'(PANEL_SIDE))
                  && (32'(tx) < MODULES * 8);
  assign pix_we = cmd.pix_write && pix_ok;
  assign waddr  = AW'(32'(ty) * GROUPS + (32'(tx) >> 6));
  assign wbit   = 6'(63 - (32'(tx) & 63));
  assign raddr  = AW'(32'(cmd.row) * GROUPS + 32'(cmd.grp));

  // Write one bit into a live word, or a fresh word into a cleared one
  always_ff @(posedge clk) begin
    if (pix_we) begin
      if (valid[waddr]) begin
        mem[waddr][wbit] <= color;
      end else begin
        mem[waddr] <= {63'd0, color} << wbit;
      end
    end
  end

  // Register the read word and whether it holds data
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_word <= mem[raddr];
      rd_ok   <= valid[raddr];
    end
  end

  // Clear the valid bits of all words at once on reset or clear
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid <= '0;
    end else if (pix_we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Latch the broadcast register and byte, clamping brightness
  always_ff @(posedge clk) begin
    if (cmd.latch_cmd) begin
      if (cmd.bright) begin
        bc_addr <= INTENSITY_REG;
        bc_byte <= (cmd_data > MAX_BRIGHT) ? MAX_BRIGHT : cmd_data;
      end else begin
        bc_addr <= cmd_address;
        bc_byte <= cmd_data;
      end
    end
  end

  // Fill lanes that map to a real module, zero the rest
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      bc_word[63 - 8 * b -: 8] = ((32'(cmd.grp) * 8 + b) < MODULES) ? bc_byte : 8'h00;
    end
  end

  // Output register: load a group, drop valid on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_mem || cmd.load_bcast) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      out_addr    <= DIGIT_BASE + 4'(cmd.row);
      out_payload <= rd_ok ? rd_word : 64'd0;
    end else if (cmd.load_bcast) begin
      out_addr    <= bc_addr;
      out_payload <= bc_word;
    end
    if (cmd.load_mem || cmd.load_bcast) begin
      out_grp  <= cmd.grp[0];
      out_fend <= cmd.frame_end;
      out_last <= cmd.last;
    end
  end

  assign stat.out_free   = !out_valid || rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.reg_address = out_addr;
  assign rsp.payload     = out_payload;
  assign rsp.group_index = out_grp;
  assign rsp.frame_end   = out_fend;
  assign rsp.last        = out_last;

endmodule

[rtl/led_matrix_framebuffer_refresh.sv]
`timescale 1ns / 1ps
// Channel  Dir  Carries
// req      in   func, x, y, color, cmd_address, cmd_data (one operation)
// rsp      out  reg_address, payload, group_index, frame_end, last (one group)
//
// Pixel write, clear and unused codes are handled in S_IDLE and can be taken back to back.
// Show steps through every row and group, reading each word, then loading
// it into the output register; the load waits while the output is stalled.
// Broadcasts load one group per cycle while the output is not stalled.
// Reset clears the per-word valid bits all at once; no clearing pass.
// A stalled result holds the output register; the next operation is taken
// while the last result of the previous one still waits.

module led_matrix_framebuffer_refresh import lmfr_pkg::*; #(
  parameter int MODULES    = MODULES_DEF,
  parameter int PANEL_SIDE = PANEL_SIDE_DEF
) (
  input  logic     clk,
  input  logic     rst,
  lmfr_op_if.sink  req,
  lmfr_grp_if.source rsp
);

  lmfr_cmd_t  cmd;
  lmfr_stat_t stat;
  logic       ctrl_ready;

  assign req.ready = ctrl_ready;

  lmfr_ctrl #(
    .MODULES (MODULES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_func  (req.func),
    .in_ready (ctrl_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lmfr_datapath #(
    .MODULES    (MODULES),
    .PANEL_SIDE (PANEL_SIDE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .x           (req.x),
    .y           (req.y),
    .color       (req.color),
    .cmd_address (req.cmd_address),
    .cmd_data    (req.cmd_data),
    .cmd         (cmd),
    .stat        (stat),
    .rsp         (rsp)
  );

endmodule

[rtl/lmfr_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  rsp_reg_address,
  input logic [63:0] rsp_payload,
  input logic        rsp_group_index,
  input logic        rsp_frame_end,
  input logic        rsp_last
);

  // Stalled result holds still
  `LMFR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload) && $stable(rsp_reg_address) && $stable(rsp_group_index) && $stable(rsp_frame_end) && $stable(rsp_last))

  // The final result of an operation closes its frame
  `LMFR_ASSERT_IMPL(a_last_ends_frame, clk, rst, rsp_valid && rsp_last, rsp_frame_end)

  // No new operation while results of the current one remain
  `LMFR_ASSERT_IMPL(a_busy_mid_op, clk, rst, rsp_valid && !rsp_last, !req_ready)

  // A group inside a frame is never the final one
  `LMFR_ASSERT_IMPL(a_mid_not_last, clk, rst, rsp_valid && !rsp_frame_end, !rsp_last)

endmodule

bind led_matrix_framebuffer_refresh lmfr_checker u_lmfr_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_reg_address (rsp.reg_address),
  .rsp_payload     (rsp.payload),
  .rsp_group_index (rsp.group_index),
  .rsp_frame_end   (rsp.frame_end),
  .rsp_last        (rsp.last)
);
